// ===== sv/pfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsa_pkg: shared definitions for the page frame stack allocator
// Status codes, configuration register indexes, controller/datapath
// command and status bundles, request types, page geometry, default sizing.
// ----------------------------------------------------------------------------
package pfsa_pkg;

    // default sizing
    localparam int DEF_STACK_DEPTH      = 4096;
    localparam int DEF_ENTRIES_PER_PAGE = 1024;

    // page geometry
    localparam logic [31:0] PAGE_BYTES     = 32'h0000_1000;
    localparam logic [31:0] PAGE_ADDR_MASK = 32'hFFFF_F000;

    // result status codes
    localparam int          STATUS_W           = 3;
    localparam logic [2:0]  ST_ALLOCATED       = 3'd0;
    localparam logic [2:0]  ST_OUT_OF_MEMORY   = 3'd1;
    localparam logic [2:0]  ST_FREE_IGNORED    = 3'd2;
    localparam logic [2:0]  ST_PUSHED          = 3'd3;
    localparam logic [2:0]  ST_USED_AS_STORAGE = 3'd4;
    localparam logic [2:0]  ST_DROPPED         = 3'd5;

    // configuration register indexes
    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  CFG_STACK_MODE = 2'd0;
    localparam logic [1:0]  CFG_START_ADDR = 2'd1;

    // request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;   // latch the incoming request
        logic exec;     // evaluate latched request, update state
        logic pop_out;  // present popped entry as the result
    } t_dp_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic is_pop;   // latched request pops the free stack
    } t_dp_stat;

endpackage

// ===== sv/pfsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfsa_ctrl: request sequencer
// Accepts a request, steps the datapath through evaluation, and on a pop
// passes through a pop state that waits for the stack memory read.
// ----------------------------------------------------------------------------
module pfsa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pfsa_pkg::t_dp_stat i_stat,
    output logic               o_busy,
    output pfsa_pkg::t_dp_cmd  o_cmd
);
    import pfsa_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.is_pop ? S_POP : S_IDLE;
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // commands
    assign o_busy         = (r_state != S_IDLE);
    assign o_cmd.accept   = (r_state == S_IDLE) && i_start;
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.pop_out  = (r_state == S_POP);

endmodule

// ===== sv/pfsa_datapath.sv =====
// ----------------------------------------------------------------------------
// pfsa_datapath: allocator state, free stack memory and result register
// Holds bump pointer, stack count and capacity, the configuration, the
// free page stack, and drives the one-cycle result strobe.
// ----------------------------------------------------------------------------
module pfsa_datapath #(
    parameter int STACK_DEPTH      = pfsa_pkg::DEF_STACK_DEPTH,
    parameter int ENTRIES_PER_PAGE = pfsa_pkg::DEF_ENTRIES_PER_PAGE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pfsa_pkg::t_dp_cmd          i_cmd,
    output pfsa_pkg::t_dp_stat         o_stat,
    input  logic                       i_req_type,
    input  logic [31:0]                i_page_address,
    input  logic                       i_cfg_we,
    input  logic [pfsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                i_cfg_data,
    output logic                       o_valid,
    output logic [31:0]                o_alloc_address,
    output logic [pfsa_pkg::STATUS_W-1:0] o_status
);
    import pfsa_pkg::*;

    localparam int  CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int  AW        = $clog2(STACK_DEPTH);
    localparam bit  GROW_OK   = (ENTRIES_PER_PAGE <= STACK_DEPTH);
    localparam int  CAP_LIMIT = GROW_OK ? (STACK_DEPTH - ENTRIES_PER_PAGE) : 0;

    // configuration and allocator state
    logic              r_stack_mode;
    logic [31:0]       r_bump;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_capacity;

    // latched request
    logic              r_req_type;
    logic [31:0]       r_page;

    // free stack memory
    logic [31:0]       r_mem [STACK_DEPTH];
    logic [31:0]       r_rd_data;

    // result register
    logic              r_out_valid;
    logic [31:0]       r_out_addr;
    logic [STATUS_W-1:0] r_out_status;

    // decode of the latched request
    logic              is_alloc;
    logic              is_pop;
    logic              is_ignored;
    logic              is_full;
    logic              can_grow;
    logic              can_push;
    logic              do_push;
    logic              do_grow;
    logic [31:0]       bump_inc;
    logic [CNT_W-1:0]  count_dec;

    assign is_alloc   = (r_req_type == REQ_ALLOC);
    assign is_pop     = is_alloc && r_stack_mode && (r_count != '0);
    assign is_ignored = !is_alloc && (r_page < r_bump);
    assign is_full    = (r_capacity <= r_count);
    assign can_grow   = GROW_OK && (r_capacity <= CNT_W'(CAP_LIMIT));
    assign can_push   = (r_count < CNT_W'(STACK_DEPTH));
    assign do_grow    = !is_alloc && !is_ignored && is_full && can_grow;
    assign do_push    = !is_alloc && !is_ignored && !is_full && can_push;
    assign bump_inc   = r_bump + PAGE_BYTES;
    assign count_dec  = r_count - CNT_W'(1);

    assign o_stat.is_pop = is_pop;

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_page     <= i_page_address;
        end
    end

    // configuration, bump pointer, stack counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_mode <= 1'b0;
            r_bump       <= PAGE_BYTES;
            r_count      <= '0;
            r_capacity   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STACK_MODE: r_stack_mode <= i_cfg_data[0];
                CFG_START_ADDR: r_bump       <= (i_cfg_data + PAGE_BYTES) & PAGE_ADDR_MASK;
                default:        ;
            endcase
        end else if (i_cmd.exec) begin
            if (is_alloc && !r_stack_mode) r_bump <= bump_inc;
            if (is_pop)  r_count    <= count_dec;
            if (do_push) r_count    <= r_count + CNT_W'(1);
            if (do_grow) r_capacity <= r_capacity + CNT_W'(ENTRIES_PER_PAGE);
        end
    end

    // stack memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_push) r_mem[r_count[AW-1:0]] <= r_page;
    end

    // stack memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && is_pop) r_rd_data <= r_mem[count_dec[AW-1:0]];
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_valid <= 1'b0;
        else          r_out_valid <= (i_cmd.exec && !is_pop) || i_cmd.pop_out;
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_out) begin
            r_out_addr   <= r_rd_data;
            r_out_status <= ST_ALLOCATED;
        end else if (i_cmd.exec) begin
            r_out_addr <= '0;
            if (is_alloc) begin
                if (!r_stack_mode) begin
                    r_out_addr   <= bump_inc;
                    r_out_status <= ST_ALLOCATED;
                end else begin
                    r_out_status <= ST_OUT_OF_MEMORY;
                end
            end else if (is_ignored) begin
                r_out_status <= ST_FREE_IGNORED;
            end else if (do_grow) begin
                r_out_status <= ST_USED_AS_STORAGE;
            end else if (do_push) begin
                r_out_status <= ST_PUSHED;
            end else begin
                r_out_status <= ST_DROPPED;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_alloc_address = r_out_addr;
    assign o_status        = r_out_status;

endmodule

// ===== sv/page_frame_stack_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// page_frame_stack_allocator_unit: physical page allocator
// Bump allocation before paging, free page stack afterwards.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req_type (0 allocate, 1 free) and
//   i_page_address with start high; the transfer happens at a clock edge
//   where start is high and busy is low.
//   Result channel: o_valid is high for exactly one cycle with
//   o_alloc_address and o_status; the receiver cannot stall it.
//   Configuration: i_cfg_valid/o_cfg_ready carry i_cfg_index and
//   i_cfg_data; index 0 is stack_mode, index 1 is start_address (a write
//   reloads the bump pointer). Write only while the unit is idle.
// Timing:
//   The request is latched at acceptance and evaluated in the execute state;
//   o_valid comes from the result register. A stack pop passes through a
//   further pop state for the registered stack memory read.
//   The controller handles one request at a time: busy stays high until the
//   result is registered, so a new request waits for the last one.
// Reset:
//   Synchronous, active low. Counters, capacity and mode clear, the bump
//   pointer loads 0x1000. Stack memory contents are not cleared.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_unit #(
    parameter int STACK_DEPTH      = pfsa_pkg::DEF_STACK_DEPTH,
    parameter int ENTRIES_PER_PAGE = pfsa_pkg::DEF_ENTRIES_PER_PAGE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [31:0]                   i_page_address,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pfsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output logic                          o_valid,
    output logic [31:0]                   o_alloc_address,
    output logic [pfsa_pkg::STATUS_W-1:0] o_status
);
    import pfsa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // configuration transfers are always taken
    assign o_cfg_ready = 1'b1;

    pfsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    pfsa_datapath #(
        .STACK_DEPTH      (STACK_DEPTH),
        .ENTRIES_PER_PAGE (ENTRIES_PER_PAGE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_req_type      (i_req_type),
        .i_page_address  (i_page_address),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_alloc_address (o_alloc_address),
        .o_status        (o_status)
    );

endmodule

// ===== dv/pfsa_outcome_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsa_outcome_tracker: result predictor and comparator for the allocator
// Watches request, configuration and result transfers, keeps its own copy
// of the allocator state, and compares each result in order of arrival.
// ----------------------------------------------------------------------------
module pfsa_outcome_tracker #(
    parameter int STACK_DEPTH      = pfsa_pkg::DEF_STACK_DEPTH,
    parameter int ENTRIES_PER_PAGE = pfsa_pkg::DEF_ENTRIES_PER_PAGE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_req_type,
    input  logic [31:0]                    i_page_address,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [pfsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_res_valid,
    input  logic [31:0]                    i_res_addr,
    input  logic [pfsa_pkg::STATUS_W-1:0]  i_res_status,
    output int                             o_err_count,
    output int                             o_pending
);
    import pfsa_pkg::*;

    typedef struct packed {
        logic [31:0]         addr;
        logic [STATUS_W-1:0] status;
    } t_page_grant;

    // shadow allocator state
    logic [31:0] freed_pages [STACK_DEPTH];
    int          page_count;
    int          page_capacity;
    logic [31:0] bump_ptr;
    logic        stack_mode;
    logic [31:0] start_addr;

    t_page_grant grants_due[$];
    int          mismatches;

    assign o_err_count = mismatches;
    assign o_pending   = grants_due.size();

    // one request against the shadow state, returns its outcome
    function automatic t_page_grant serve_request(logic req, logic [31:0] page);
        t_page_grant g;
        g.addr   = '0;
        g.status = ST_ALLOCATED;
        if (req == REQ_ALLOC) begin
            if (stack_mode) begin
                if (page_count == 0 || page_count > STACK_DEPTH) begin
                    g.status = ST_OUT_OF_MEMORY;
                end else begin
                    page_count = page_count - 1;
                    g.addr     = freed_pages[page_count];
                end
            end else begin
                bump_ptr = bump_ptr + PAGE_BYTES;
                g.addr   = bump_ptr;
            end
        end else if (page < bump_ptr) begin
            g.status = ST_FREE_IGNORED;
        end else if (page_capacity <= page_count) begin
            // no room left: the page becomes stack storage, unless at the bound
            if (page_capacity + ENTRIES_PER_PAGE > STACK_DEPTH) begin
                g.status = ST_DROPPED;
            end else begin
                page_capacity = page_capacity + ENTRIES_PER_PAGE;
                g.status      = ST_USED_AS_STORAGE;
            end
        end else if (page_count < STACK_DEPTH) begin
            freed_pages[page_count] = page;
            page_count              = page_count + 1;
            g.status                = ST_PUSHED;
        end else begin
            g.status = ST_DROPPED;
        end
        return g;
    endfunction

    always @(posedge i_clk) begin
        t_page_grant want;
        if (!i_rst_n) begin
            foreach (freed_pages[k]) freed_pages[k] = '0;
            page_count    = 0;
            page_capacity = 0;
            bump_ptr      = PAGE_BYTES;
            stack_mode    = 1'b0;
            start_addr    = '0;
            grants_due.delete();
            mismatches    = 0;
        end else begin
            // register writes; unknown indexes fall through
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STACK_MODE: stack_mode = i_cfg_data[0];
                    CFG_START_ADDR: begin
                        start_addr = i_cfg_data;
                        bump_ptr   = (start_addr + PAGE_BYTES) & PAGE_ADDR_MASK;
                    end
                    default: ;
                endcase
            end
            // request transfer
            if (i_start && !i_busy) begin
                grants_due.push_back(serve_request(i_req_type, i_page_address));
            end
            // result transfer
            if (i_res_valid) begin
                if (grants_due.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result addr %h status %0d", $realtime,
                                 i_res_addr, i_res_status);
                    mismatches = mismatches + 1;
                end else begin
                    want = grants_due.pop_front();
                    if (i_res_addr !== want.addr || i_res_status !== want.status) begin
                        if (mismatches < 10)
                            $display("%0t: expected addr %h status %0d, got addr %h status %0d",
                                     $realtime, want.addr, want.status, i_res_addr,
                                     i_res_status);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/page_frame_stack_allocator_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_stack_allocator_unit_test: testbench top for the page allocator
// Directed allocate/free cases, randomized phases across mode and start
// address settings, and a free run that pushes and may grow the stack.
// Results are predicted and compared by the outcome tracker.
// ----------------------------------------------------------------------------
module page_frame_stack_allocator_unit_test;
    import pfsa_pkg::*;

    // indexes past the register list, must be ignored
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS   = 90;
    localparam int FILL_FREES    = 100;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_req_type;
    logic [31:0]          i_page_address;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 o_valid;
    logic [31:0]          o_alloc_address;
    logic [STATUS_W-1:0]  o_status;

    int err_count;
    int pending;
    bit no_idle;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    page_frame_stack_allocator_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_page_address  (i_page_address),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_alloc_address (o_alloc_address),
        .o_status        (o_status)
    );

    pfsa_outcome_tracker u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_req_type     (i_req_type),
        .i_page_address (i_page_address),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_res_valid    (o_valid),
        .i_res_addr     (o_alloc_address),
        .i_res_status   (o_status),
        .o_err_count    (err_count),
        .o_pending      (pending)
    );

    // one request transfer; start stays high afterwards for back-to-back items
    task automatic send_item(input logic req, input logic [31:0] addr);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= req;
        i_page_address <= addr;
        do @(posedge i_clk); while (busy);
    endtask

    // register write, only once every outstanding result is back
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // free address: mostly wide random, some at the extremes or low
    function automatic logic [31:0] pick_page();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 32'h1FFF);
            3:       return $urandom & PAGE_ADDR_MASK;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_random(input int n, input int alloc_pct);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(1, 100) <= alloc_pct)
                send_item(REQ_ALLOC, $urandom);
            else
                send_item(REQ_FREE, pick_page());
        end
    endtask

    // stimulus and verdict
    initial begin
        int waited;
        logic [31:0] start_pick;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_req_type     <= REQ_ALLOC;
        i_page_address <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_STACK_MODE;
        i_cfg_data     <= '0;
        no_idle        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bump mode out of reset, frees handled the same in either mode
        send_item(REQ_ALLOC, 32'hFFFF_FFFF);
        send_item(REQ_ALLOC, 32'h0000_0000);
        send_item(REQ_FREE, 32'h0000_0000);
        send_item(REQ_FREE, 32'hFFFF_FFFF);
        send_item(REQ_FREE, 32'hFFFF_FFFF);
        send_item(REQ_FREE, 32'h0000_1000);

        // bump pointer wraps past the top
        write_reg(CFG_START_ADDR, 32'hFFFF_E000);
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_FREE, 32'hFFFF_FFFF);

        // stack mode: pops, then empty stack
        write_reg(CFG_STACK_MODE, 32'h1);
        no_idle = 1'b1;
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_FREE, 32'h0000_0FFF);
        send_item(REQ_FREE, 32'h0000_1000);
        send_item(REQ_ALLOC, 32'h0);
        send_item(REQ_ALLOC, 32'h0);
        no_idle = 1'b0;

        // writes to indexes past the list, then check nothing moved
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'h0000_0000);
        send_item(REQ_FREE, 32'h0000_0000);
        send_item(REQ_FREE, 32'hABCD_E000);
        send_item(REQ_ALLOC, 32'h0);
        write_reg(CFG_START_ADDR, 32'hFFFF_FFFF);
        send_item(REQ_FREE, 32'h0000_0000);
        send_item(REQ_ALLOC, 32'h0);

        // random phases over several settings
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 5)
                0:       start_pick = 32'h0000_0000;
                1:       start_pick = 32'hFFFF_FFFF;
                2:       start_pick = 32'hFFFF_E000;
                3:       start_pick = $urandom;
                default: start_pick = $urandom_range(0, 32'hFFFF);
            endcase
            write_reg(CFG_STACK_MODE, (ph % 3 == 2) ? 32'h0 : {$urandom} | 32'h1);
            write_reg(CFG_START_ADDR, start_pick);
            no_idle = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       run_random(PHASE_ITEMS, 25);
                1:       run_random(PHASE_ITEMS, 50);
                default: run_random(PHASE_ITEMS, 75);
            endcase
        end

        // run of frees that pushes and may grow the stack, then mixed traffic
        write_reg(CFG_STACK_MODE, 32'hFFFF_FFFE | 32'h1);
        write_reg(CFG_START_ADDR, 32'hFFFF_FFFF);
        for (int k = 0; k < FILL_FREES; k++) begin
            no_idle = ($urandom_range(0, 7) != 0);
            send_item(REQ_FREE, $urandom);
        end
        no_idle = 1'b0;
        run_random(60, 50);

        // drain
        start <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("page_frame_stack_allocator_unit_test: done, clean");
        end else begin
            $display("page_frame_stack_allocator_unit_test: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("page_frame_stack_allocator_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pfsa_pkg.sv
sv/pfsa_ctrl.sv
sv/pfsa_datapath.sv
sv/page_frame_stack_allocator_unit.sv
dv/pfsa_outcome_tracker.sv
dv/page_frame_stack_allocator_unit_test.sv
